>>> sv/pdbp_pkg.sv
package pdbp_pkg;

   localparam int MAX_BLOCK   = 1024;
   localparam int CHANNELS    = 2;
   localparam int FC_W        = $clog2(MAX_BLOCK + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] CMD_FIRST  = 2'd0;
   localparam logic [1:0] CMD_SECOND = 2'd1;
   localparam logic [1:0] CMD_FRAME  = 2'd2;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_FRAME  = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   localparam logic [1:0] CSR_SHIFT_AMOUNT      = 2'd0;
   localparam logic [1:0] CSR_DC_ALPHA          = 2'd1;
   localparam logic [1:0] CSR_SAMPLES_PER_BLOCK = 2'd2;

   localparam logic [4:0]  SHIFT_RESET = 5'd16;
   localparam logic [14:0] ALPHA_RESET = 15'd32440;
   localparam logic [10:0] SPB_RESET   = 11'd320;

   typedef struct packed {
      logic [4:0]  shift_amount;
      logic [14:0] dc_alpha;
      logic [10:0] samples_per_block;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] x_left;
      logic signed [31:0] x_right;
   } item_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] pcm_left;
      logic signed [15:0] pcm_right;
      logic [14:0]        peak_left;
      logic [14:0]        peak_right;
      logic               block_end;
      logic               half_index;
      logic [15:0]        overrun_count;
      logic [15:0]        sequence_error_count;
      logic [1:0]         pending_halves;
      logic [47:0]        total_samples;
   } rsp_type;

endpackage

>>> sv/pdbp_front.sv
module pdbp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_cmd,
   input  logic signed [31:0]       req_raw_left,
   input  logic signed [31:0]       req_raw_right,
   input  logic [4:0]               shift_amount,
   output logic                     q_valid,
   output pdbp_pkg::item_type       q_item,
   input  logic                     q_pop
);

   pdbp_pkg::item_type entry_ff [pdbp_pkg::QUEUE_DEPTH];
   logic [pdbp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pdbp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pdbp_pkg::QPTR_W:0]   count_ff, count_in;
   logic push, pop;
   pdbp_pkg::item_type push_item;

   assign req_stall = (count_ff == (pdbp_pkg::QPTR_W+1)'(pdbp_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = entry_ff[rd_ptr_ff];

   // The shift is applied on entry so the back end only sees scaled samples.
   always_comb begin
      push_item.cmd     = req_cmd;
      push_item.x_left  = req_raw_left >>> shift_amount;
      push_item.x_right = req_raw_right >>> shift_amount;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> sv/pdbp_back.sv
module pdbp_back (
   input  logic                clock,
   input  logic                reset,
   input  pdbp_pkg::cfg_type   cfg,
   input  logic                q_valid,
   input  pdbp_pkg::item_type  q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pdbp_pkg::rsp_type   rsp
);

   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic signed [31:0] dc_filter(input logic signed [31:0] x,
                                                    input logic signed [31:0] x1,
                                                    input logic signed [31:0] y1,
                                                    input logic [14:0] alpha);
      logic signed [47:0] prod;
      logic signed [32:0] fb;
      logic signed [34:0] acc;
      prod = $signed({1'b0, alpha}) * y1;
      fb   = 33'(prod >>> 15);
      acc  = 35'(x) - 35'(x1) + 35'(fb);
      if (acc > 35'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (acc < -35'sd2147483648) begin
         return 32'sh80000000;
      end
      return acc[31:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [31:0] y);
      if (y > 32'sd32767) begin
         return 16'sh7FFF;
      end else if (y < -32'sd32768) begin
         return 16'sh8000;
      end
      return y[15:0];
   endfunction

   // The most negative code counts as full scale for the peak.
   function automatic logic [14:0] magnitude(input logic signed [15:0] q);
      logic [15:0] neg;
      neg = 16'(-q);
      if (!q[15]) begin
         return q[14:0];
      end else if (q == 16'sh8000) begin
         return 15'h7FFF;
      end
      return neg[14:0];
   endfunction

   logic [1:0]                    pending_ff, pending_in;
   logic                          last_half_ff, last_half_in;
   logic                          announced_ff, announced_in;
   logic                          expected_ff, expected_in;
   logic                          in_block_ff, in_block_in;
   logic                          current_ff, current_in;
   logic [pdbp_pkg::FC_W-1:0]     frame_count_ff, frame_count_in;
   logic [14:0]                   peak_ff [pdbp_pkg::CHANNELS];
   logic [14:0]                   peak_in [pdbp_pkg::CHANNELS];
   logic signed [31:0]            prev_x_ff [pdbp_pkg::CHANNELS];
   logic signed [31:0]            prev_x_in [pdbp_pkg::CHANNELS];
   logic signed [31:0]            prev_y_ff [pdbp_pkg::CHANNELS];
   logic signed [31:0]            prev_y_in [pdbp_pkg::CHANNELS];
   logic [15:0]                   overruns_ff, overruns_in;
   logic [15:0]                   seq_err_ff, seq_err_in;
   logic [47:0]                   total_ff, total_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pdbp_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          take;
   logic [pdbp_pkg::FC_W-1:0]     block_len;

   assign take      = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop     = take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Block length clamped into one to MAX_BLOCK frames.
   always_comb begin
      if (cfg.samples_per_block == '0) begin
         block_len = pdbp_pkg::FC_W'(1);
      end else if (int'(cfg.samples_per_block) > pdbp_pkg::MAX_BLOCK) begin
         block_len = pdbp_pkg::FC_W'(pdbp_pkg::MAX_BLOCK);
      end else begin
         block_len = pdbp_pkg::FC_W'(cfg.samples_per_block);
      end
   end

   always_comb begin
      logic signed [31:0]        xs  [pdbp_pkg::CHANNELS];
      logic signed [15:0]        pcm [pdbp_pkg::CHANNELS];
      logic signed [31:0]        y;
      logic [14:0]               mag;
      logic                      h;
      logic [pdbp_pkg::FC_W-1:0] fc;
      logic [1:0]                kind;
      logic                      half;
      logic                      bend;

      xs[0] = q_item.x_left;
      xs[1] = q_item.x_right;

      pending_in     = pending_ff;
      last_half_in   = last_half_ff;
      announced_in   = announced_ff;
      expected_in    = expected_ff;
      in_block_in    = in_block_ff;
      current_in     = current_ff;
      frame_count_in = frame_count_ff;
      overruns_in    = overruns_ff;
      seq_err_in     = seq_err_ff;
      total_in       = total_ff;
      for (int c = 0; c < pdbp_pkg::CHANNELS; c++) begin
         peak_in[c]   = peak_ff[c];
         prev_x_in[c] = prev_x_ff[c];
         prev_y_in[c] = prev_y_ff[c];
         pcm[c]       = '0;
      end
      kind = pdbp_pkg::KIND_STATUS;
      half = last_half_ff;
      bend = 1'b0;
      h    = current_ff;
      fc   = frame_count_ff;
      y    = '0;
      mag  = '0;

      case (q_item.cmd)
         pdbp_pkg::CMD_FIRST, pdbp_pkg::CMD_SECOND: begin
            if (pending_ff[q_item.cmd[0]]) begin
               overruns_in = sat_inc16(overruns_ff);
            end
            if (announced_ff && last_half_ff == q_item.cmd[0]) begin
               seq_err_in = sat_inc16(seq_err_ff);
            end
            announced_in = 1'b1;
            pending_in[q_item.cmd[0]] = 1'b1;
            last_half_in = q_item.cmd[0];
            half = q_item.cmd[0];
         end
         pdbp_pkg::CMD_FRAME: begin
            if (!in_block_ff && pending_ff == 2'b00) begin
               kind = pdbp_pkg::KIND_REJECT;
               half = expected_ff;
            end else begin
               if (!in_block_ff) begin
                  // Open a block; fall back to the other half on a resync.
                  h = expected_ff;
                  if (!pending_ff[h]) begin
                     seq_err_in = sat_inc16(seq_err_ff);
                     h = ~h;
                  end
                  fc = '0;
                  for (int c = 0; c < pdbp_pkg::CHANNELS; c++) begin
                     peak_in[c] = '0;
                  end
               end
               current_in  = h;
               in_block_in = 1'b1;
               kind = pdbp_pkg::KIND_FRAME;
               half = h;
               for (int c = 0; c < pdbp_pkg::CHANNELS; c++) begin
                  if (cfg.dc_alpha != '0) begin
                     y = dc_filter(xs[c], prev_x_ff[c], prev_y_ff[c], cfg.dc_alpha);
                     prev_x_in[c] = xs[c];
                     prev_y_in[c] = y;
                  end else begin
                     y = xs[c];
                  end
                  pcm[c] = sat16(y);
                  mag    = magnitude(pcm[c]);
                  if (mag > peak_in[c]) begin
                     peak_in[c] = mag;
                  end
               end
               fc = fc + 1'b1;
               frame_count_in = fc;
               if (fc >= block_len) begin
                  bend           = 1'b1;
                  total_in       = total_ff + 48'(fc);
                  expected_in    = ~h;
                  pending_in[h]  = 1'b0;
                  in_block_in    = 1'b0;
                  frame_count_in = '0;
               end
            end
         end
         default: begin
         end
      endcase

      rsp_in.kind                 = kind;
      rsp_in.pcm_left             = pcm[0];
      rsp_in.pcm_right            = pcm[1];
      rsp_in.peak_left            = peak_in[0];
      rsp_in.peak_right           = peak_in[1];
      rsp_in.block_end            = bend;
      rsp_in.half_index           = half;
      rsp_in.overrun_count        = overruns_in;
      rsp_in.sequence_error_count = seq_err_in;
      rsp_in.pending_halves       = pending_in;
      rsp_in.total_samples        = total_in;
   end

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff     <= '0;
         last_half_ff   <= 1'b0;
         announced_ff   <= 1'b0;
         expected_ff    <= 1'b0;
         in_block_ff    <= 1'b0;
         current_ff     <= 1'b0;
         frame_count_ff <= '0;
         overruns_ff    <= '0;
         seq_err_ff     <= '0;
         total_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int c = 0; c < pdbp_pkg::CHANNELS; c++) begin
            peak_ff[c]   <= '0;
            prev_x_ff[c] <= '0;
            prev_y_ff[c] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            pending_ff     <= pending_in;
            last_half_ff   <= last_half_in;
            announced_ff   <= announced_in;
            expected_ff    <= expected_in;
            in_block_ff    <= in_block_in;
            current_ff     <= current_in;
            frame_count_ff <= frame_count_in;
            overruns_ff    <= overruns_in;
            seq_err_ff     <= seq_err_in;
            total_ff       <= total_in;
            for (int c = 0; c < pdbp_pkg::CHANNELS; c++) begin
               peak_ff[c]   <= peak_in[c];
               prev_x_ff[c] <= prev_x_in[c];
               prev_y_ff[c] <= prev_y_in[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> sv/pingpong_dc_block_peak_unit.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  cmd, raw_left, raw_right
// rsp_      out        rsp_valid / rsp_stall  kind, pcm, peaks, status, counters
// csr_      in         csr_we                 csr_index, csr_wdata
//
// One item is accepted per cycle while the queue is not full; its single result
// passes the four-entry input queue, then the filter and bookkeeping stage with
// its output register. If results are not stalled, that rate is set by the
// per-channel feedback loop (one multiply, add and saturate) in that stage.
// Reset is synchronous, clears control and filter state, loads register defaults.
// A stalled result holds while the queue keeps taking items until it is full.
module pingpong_dc_block_peak_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_raw_left,
   input  logic signed [31:0] req_raw_right,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [15:0] rsp_pcm_left,
   output logic signed [15:0] rsp_pcm_right,
   output logic [14:0]        rsp_peak_left,
   output logic [14:0]        rsp_peak_right,
   output logic               rsp_block_end,
   output logic               rsp_half_index,
   output logic [15:0]        rsp_overrun_count,
   output logic [15:0]        rsp_sequence_error_count,
   output logic [1:0]         rsp_pending_halves,
   output logic [47:0]        rsp_total_samples,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_wdata
);

   pdbp_pkg::cfg_type  cfg_ff, cfg_in;
   logic               q_valid;
   logic               q_pop;
   pdbp_pkg::item_type q_item;
   pdbp_pkg::rsp_type  rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pdbp_pkg::CSR_SHIFT_AMOUNT:      cfg_in.shift_amount      = csr_wdata[4:0];
            pdbp_pkg::CSR_DC_ALPHA:          cfg_in.dc_alpha          = csr_wdata;
            pdbp_pkg::CSR_SAMPLES_PER_BLOCK: cfg_in.samples_per_block = csr_wdata[10:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shift_amount      <= pdbp_pkg::SHIFT_RESET;
         cfg_ff.dc_alpha          <= pdbp_pkg::ALPHA_RESET;
         cfg_ff.samples_per_block <= pdbp_pkg::SPB_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pdbp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_raw_left  (req_raw_left),
      .req_raw_right (req_raw_right),
      .shift_amount  (cfg_ff.shift_amount),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   pdbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_kind                 = rsp.kind;
   assign rsp_pcm_left             = rsp.pcm_left;
   assign rsp_pcm_right            = rsp.pcm_right;
   assign rsp_peak_left            = rsp.peak_left;
   assign rsp_peak_right           = rsp.peak_right;
   assign rsp_block_end            = rsp.block_end;
   assign rsp_half_index           = rsp.half_index;
   assign rsp_overrun_count        = rsp.overrun_count;
   assign rsp_sequence_error_count = rsp.sequence_error_count;
   assign rsp_pending_halves       = rsp.pending_halves;
   assign rsp_total_samples        = rsp.total_samples;

endmodule

>>> test/pdbp_capture_checker.sv
module pdbp_capture_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_raw_left,
   input  logic signed [31:0] req_raw_right,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_kind,
   input  logic signed [15:0] rsp_pcm_left,
   input  logic signed [15:0] rsp_pcm_right,
   input  logic [14:0]        rsp_peak_left,
   input  logic [14:0]        rsp_peak_right,
   input  logic               rsp_block_end,
   input  logic               rsp_half_index,
   input  logic [15:0]        rsp_overrun_count,
   input  logic [15:0]        rsp_sequence_error_count,
   input  logic [1:0]         rsp_pending_halves,
   input  logic [47:0]        rsp_total_samples,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_wdata,
   output int                 mismatches,
   output int                 open_results
);

   localparam longint ACC_MAX = 64'sd2147483647;
   localparam longint ACC_MIN = -64'sd2147483648;

   logic [4:0]         shift_cfg;
   logic [14:0]        alpha_cfg;
   logic [10:0]        block_len_cfg;

   logic [1:0]         pending;
   logic               last_half;
   logic               any_announced;
   logic               next_half;
   logic               block_open;
   logic               open_half;
   logic [10:0]        frames_done;
   logic [14:0]        peak_mag [2];
   logic signed [31:0] x_prev [2];
   logic signed [31:0] y_prev [2];
   logic [15:0]        overruns;
   logic [15:0]        seq_errors;
   logic [47:0]        frames_total;

   pdbp_pkg::rsp_type  awaited_results [$];
   pdbp_pkg::rsp_type  want;
   int                 results_seen;

   initial begin
      mismatches = 0;
      open_results = 0;
      results_seen = 0;
   end

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hffff) ? v : v + 16'd1;
   endfunction

   // Shift, DC blocker and 16-bit clamp of one sample; updates the block peak.
   function automatic logic signed [15:0] filter_sample(input int ch,
                                                        input logic signed [31:0] raw);
      logic signed [31:0] x;
      logic signed [31:0] y;
      longint             acc;
      longint             fb;
      logic signed [15:0] q;
      logic [14:0]        mag;
      x = raw >>> shift_cfg;
      y = x;
      if (alpha_cfg != 15'd0) begin
         fb = (longint'(alpha_cfg) * longint'(y_prev[ch])) >>> 15;
         acc = longint'(x) - longint'(x_prev[ch]) + fb;
         if (acc > ACC_MAX) acc = ACC_MAX;
         if (acc < ACC_MIN) acc = ACC_MIN;
         x_prev[ch] = x;
         y_prev[ch] = acc[31:0];
         y = acc[31:0];
      end
      if (y > 32'sd32767) q = 16'sh7fff;
      else if (y < -32'sd32768) q = 16'sh8000;
      else q = y[15:0];
      // The most negative code has no positive twin, so it peaks at full scale.
      if (q == 16'sh8000) mag = 15'h7fff;
      else if (q < 0) mag = 15'(-q);
      else mag = q[14:0];
      if (mag > peak_mag[ch]) peak_mag[ch] = mag;
      return q;
   endfunction

   function automatic pdbp_pkg::rsp_type predict_capture(input logic [1:0] cmd,
                                                         input logic signed [31:0] left,
                                                         input logic signed [31:0] right);
      pdbp_pkg::rsp_type r;
      logic              h;
      logic [10:0]       limit;
      r = '0;
      r.kind = pdbp_pkg::KIND_STATUS;
      r.half_index = last_half;
      if (cmd == pdbp_pkg::CMD_FIRST || cmd == pdbp_pkg::CMD_SECOND) begin
         h = cmd[0];
         if (pending[h]) overruns = sat_inc(overruns);
         if (any_announced && last_half == h) seq_errors = sat_inc(seq_errors);
         any_announced = 1'b1;
         pending[h] = 1'b1;
         last_half = h;
         r.half_index = h;
      end else if (cmd == pdbp_pkg::CMD_FRAME) begin
         if (!block_open && pending == 2'b00) begin
            r.kind = pdbp_pkg::KIND_REJECT;
            r.half_index = next_half;
         end else begin
            if (!block_open) begin
               h = next_half;
               // Resync onto the other half when the expected one is not pending.
               if (!pending[h]) begin
                  seq_errors = sat_inc(seq_errors);
                  h = ~h;
               end
               open_half = h;
               block_open = 1'b1;
               frames_done = '0;
               peak_mag[0] = '0;
               peak_mag[1] = '0;
            end
            r.kind = pdbp_pkg::KIND_FRAME;
            r.half_index = open_half;
            r.pcm_left = filter_sample(0, left);
            r.pcm_right = filter_sample(1, right);
            frames_done++;
            if (block_len_cfg == 11'd0) limit = 11'd1;
            else if (block_len_cfg > pdbp_pkg::MAX_BLOCK) limit = 11'(pdbp_pkg::MAX_BLOCK);
            else limit = block_len_cfg;
            if (frames_done >= limit) begin
               r.block_end = 1'b1;
               frames_total = frames_total + 48'(frames_done);
               next_half = ~open_half;
               pending[open_half] = 1'b0;
               block_open = 1'b0;
               frames_done = '0;
            end
         end
      end
      r.peak_left = peak_mag[0];
      r.peak_right = peak_mag[1];
      r.overrun_count = overruns;
      r.sequence_error_count = seq_errors;
      r.pending_halves = pending;
      r.total_samples = frames_total;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] exp_val);
      if (mismatches < 200)
         $display("result %0d: %s is %0h, should be %0h", results_seen, what, got, exp_val);
      mismatches++;
   endtask

   task automatic check_field(input string what, input logic [47:0] got,
                              input logic [47:0] exp_val);
      if (got !== exp_val) report_mismatch(what, got, exp_val);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shift_cfg = pdbp_pkg::SHIFT_RESET;
         alpha_cfg = pdbp_pkg::ALPHA_RESET;
         block_len_cfg = pdbp_pkg::SPB_RESET;
         pending = '0;
         last_half = 1'b0;
         any_announced = 1'b0;
         next_half = 1'b0;
         block_open = 1'b0;
         open_half = 1'b0;
         frames_done = '0;
         peak_mag[0] = '0;
         peak_mag[1] = '0;
         x_prev[0] = '0;
         x_prev[1] = '0;
         y_prev[0] = '0;
         y_prev[1] = '0;
         overruns = '0;
         seq_errors = '0;
         frames_total = '0;
         awaited_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               pdbp_pkg::CSR_SHIFT_AMOUNT:      shift_cfg = csr_wdata[4:0];
               pdbp_pkg::CSR_DC_ALPHA:          alpha_cfg = csr_wdata;
               pdbp_pkg::CSR_SAMPLES_PER_BLOCK: block_len_cfg = csr_wdata[10:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            awaited_results.push_back(predict_capture(req_cmd, req_raw_left, req_raw_right));
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               report_mismatch("unrequested result, kind", 48'(rsp_kind), 48'd0);
            end else begin
               want = awaited_results.pop_front();
               check_field("kind", 48'(rsp_kind), 48'(want.kind));
               check_field("pcm_left", 48'(rsp_pcm_left), 48'(want.pcm_left));
               check_field("pcm_right", 48'(rsp_pcm_right), 48'(want.pcm_right));
               check_field("peak_left", 48'(rsp_peak_left), 48'(want.peak_left));
               check_field("peak_right", 48'(rsp_peak_right), 48'(want.peak_right));
               check_field("block_end", 48'(rsp_block_end), 48'(want.block_end));
               check_field("half_index", 48'(rsp_half_index), 48'(want.half_index));
               check_field("overrun_count", 48'(rsp_overrun_count),
                           48'(want.overrun_count));
               check_field("sequence_error_count", 48'(rsp_sequence_error_count),
                           48'(want.sequence_error_count));
               check_field("pending_halves", 48'(rsp_pending_halves),
                           48'(want.pending_halves));
               check_field("total_samples", rsp_total_samples, want.total_samples);
            end
         end
      end
      open_results <= awaited_results.size();
   end

endmodule

>>> test/tb_pingpong_dc_block_peak_unit.sv
module tb_pingpong_dc_block_peak_unit;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_cmd = pdbp_pkg::CMD_FIRST;
   logic signed [31:0] req_raw_left = '0;
   logic signed [31:0] req_raw_right = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_kind;
   logic signed [15:0] rsp_pcm_left;
   logic signed [15:0] rsp_pcm_right;
   logic [14:0]        rsp_peak_left;
   logic [14:0]        rsp_peak_right;
   logic               rsp_block_end;
   logic               rsp_half_index;
   logic [15:0]        rsp_overrun_count;
   logic [15:0]        rsp_sequence_error_count;
   logic [1:0]         rsp_pending_halves;
   logic [47:0]        rsp_total_samples;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = pdbp_pkg::CSR_SHIFT_AMOUNT;
   logic [14:0]        csr_wdata = '0;

   int                 mismatches;
   int                 open_results;
   logic               calm = 1'b0;
   logic               hold_go = 1'b0;
   logic               hold_rsp = 1'b0;
   int                 stall_left = 0;
   logic               next_half = 1'b0;
   logic [10:0]        blk_len = pdbp_pkg::SPB_RESET;
   int                 phase;

   pingpong_dc_block_peak_unit dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_cmd                  (req_cmd),
      .req_raw_left             (req_raw_left),
      .req_raw_right            (req_raw_right),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_kind                 (rsp_kind),
      .rsp_pcm_left             (rsp_pcm_left),
      .rsp_pcm_right            (rsp_pcm_right),
      .rsp_peak_left            (rsp_peak_left),
      .rsp_peak_right           (rsp_peak_right),
      .rsp_block_end            (rsp_block_end),
      .rsp_half_index           (rsp_half_index),
      .rsp_overrun_count        (rsp_overrun_count),
      .rsp_sequence_error_count (rsp_sequence_error_count),
      .rsp_pending_halves       (rsp_pending_halves),
      .rsp_total_samples        (rsp_total_samples),
      .csr_we                   (csr_we),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata)
   );

   pdbp_capture_checker checker_i (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_cmd                  (req_cmd),
      .req_raw_left             (req_raw_left),
      .req_raw_right            (req_raw_right),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_kind                 (rsp_kind),
      .rsp_pcm_left             (rsp_pcm_left),
      .rsp_pcm_right            (rsp_pcm_right),
      .rsp_peak_left            (rsp_peak_left),
      .rsp_peak_right           (rsp_peak_right),
      .rsp_block_end            (rsp_block_end),
      .rsp_half_index           (rsp_half_index),
      .rsp_overrun_count        (rsp_overrun_count),
      .rsp_sequence_error_count (rsp_sequence_error_count),
      .rsp_pending_halves       (rsp_pending_halves),
      .rsp_total_samples        (rsp_total_samples),
      .csr_we                   (csr_we),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata),
      .mismatches               (mismatches),
      .open_results             (open_results)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      #(12 * 200000);
      $display("CHECK FAILED");
      $finish;
   end

   // Result side: short random stall bursts, or one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin : long_hold
      wait (hold_go);
      repeat (60) begin
         @(posedge clock);
         hold_rsp <= 1'b1;
      end
      @(posedge clock);
      hold_rsp <= 1'b0;
   end

   function automatic logic [31:0] pick_raw();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 2047) - 1024;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [1:0] ready_cmd(input logic h);
      return h ? pdbp_pkg::CMD_SECOND : pdbp_pkg::CMD_FIRST;
   endfunction

   task automatic offer(input logic [1:0] cmd, input logic [31:0] left,
                        input logic [31:0] right);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_raw_left <= left;
      req_raw_right <= right;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop sending and wait until every item has come back, plus pipeline slack.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(input logic [4:0] sh, input logic [14:0] alpha,
                               input logic [10:0] len);
      settle();
      csr_we <= 1'b1;
      csr_index <= pdbp_pkg::CSR_SHIFT_AMOUNT;
      csr_wdata <= 15'(sh);
      @(posedge clock);
      csr_index <= pdbp_pkg::CSR_DC_ALPHA;
      csr_wdata <= alpha;
      @(posedge clock);
      csr_index <= pdbp_pkg::CSR_SAMPLES_PER_BLOCK;
      csr_wdata <= 15'(len);
      @(posedge clock);
      csr_we <= 1'b0;
      blk_len = len;
   endtask

   task automatic run_phase(input int budget);
      int done;
      int n;
      done = 0;
      while (done < budget) begin
         case ($urandom_range(0, 9))
            7: begin
               offer(2'($urandom_range(0, 3)), pick_raw(), pick_raw());
               done++;
            end
            8: begin
               // Same half announced twice in a row.
               offer(ready_cmd(next_half), pick_raw(), pick_raw());
               offer(ready_cmd(next_half), pick_raw(), pick_raw());
               done += 2;
            end
            9: begin
               n = $urandom_range(1, 6);
               repeat (n) offer(pdbp_pkg::CMD_FRAME, pick_raw(), pick_raw());
               done += n;
            end
            default: begin
               offer(ready_cmd(next_half), pick_raw(), pick_raw());
               next_half = ~next_half;
               if (blk_len == 11'd0) n = 1;
               else if (blk_len > pdbp_pkg::MAX_BLOCK) n = pdbp_pkg::MAX_BLOCK;
               else n = blk_len;
               repeat (n) begin
                  // Now and then the next half becomes ready while a block is open.
                  if ($urandom_range(0, 15) == 0) begin
                     offer(ready_cmd(next_half), pick_raw(), pick_raw());
                     next_half = ~next_half;
                     done++;
                  end
                  offer(pdbp_pkg::CMD_FRAME, pick_raw(), pick_raw());
               end
               done += n + 1;
            end
         endcase
      end
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, starting from the register defaults.
      offer(pdbp_pkg::CMD_FRAME, 32'h7fffffff, 32'h80000000);
      offer(CMD_UNUSED, 32'hffffffff, 32'h00000000);
      offer(pdbp_pkg::CMD_FIRST, 32'h0, 32'h0);
      offer(pdbp_pkg::CMD_FIRST, 32'h0, 32'h0);
      offer(pdbp_pkg::CMD_SECOND, 32'h0, 32'h0);

      write_config(5'd31, 15'd0, 11'd2);
      offer(pdbp_pkg::CMD_FRAME, 32'h7fffffff, 32'h80000000);
      offer(pdbp_pkg::CMD_FRAME, 32'h80000000, 32'h7fffffff);
      offer(pdbp_pkg::CMD_FRAME, 32'hffffffff, 32'h00000001);
      offer(pdbp_pkg::CMD_FRAME, 32'h00000000, 32'hfffffffe);
      offer(pdbp_pkg::CMD_FRAME, 32'h12345678, 32'h87654321);
      // Only the second half is ready while the first is expected.
      offer(pdbp_pkg::CMD_SECOND, 32'h0, 32'h0);
      offer(pdbp_pkg::CMD_FRAME, 32'h7fffffff, 32'h7fffffff);
      offer(pdbp_pkg::CMD_FRAME, 32'h80000000, 32'h80000000);

      write_config(5'd0, 15'd32767, 11'd0);
      offer(pdbp_pkg::CMD_FIRST, 32'h0, 32'h0);
      offer(pdbp_pkg::CMD_FRAME, 32'h7fffffff, 32'h80000000);
      offer(pdbp_pkg::CMD_SECOND, 32'h0, 32'h0);
      offer(pdbp_pkg::CMD_FRAME, 32'h80000000, 32'h7fffffff);
      offer(pdbp_pkg::CMD_FIRST, 32'h0, 32'h0);
      offer(pdbp_pkg::CMD_FRAME, 32'h7fffffff, 32'h7fffffff);

      // A block opened at the largest length is cut short by a smaller one.
      write_config(5'd24, 15'd1, 11'd2047);
      offer(pdbp_pkg::CMD_SECOND, 32'h0, 32'h0);
      repeat (5) offer(pdbp_pkg::CMD_FRAME, pick_raw(), pick_raw());
      write_config(pdbp_pkg::SHIFT_RESET, pdbp_pkg::ALPHA_RESET, 11'd3);
      offer(pdbp_pkg::CMD_FRAME, pick_raw(), pick_raw());
      next_half = 1'b0;

      for (phase = 0; phase < 12; phase++) begin
         calm <= (phase % 4 == 3);
         if ($urandom_range(0, 3) == 0)
            write_config(5'($urandom_range(0, 31)), 15'($urandom_range(0, 32767)),
                         11'($urandom_range(0, 40)));
         else
            write_config(5'($urandom_range(10, 20)),
                         ($urandom_range(0, 1) == 0) ? 15'd32767 : pdbp_pkg::ALPHA_RESET,
                         11'($urandom_range(1, 8)));
         if (phase == 4) hold_go <= 1'b1;
         run_phase(10);
      end

      calm <= 1'b0;
      write_config(pdbp_pkg::SHIFT_RESET, pdbp_pkg::ALPHA_RESET, 11'(pdbp_pkg::MAX_BLOCK));
      offer(ready_cmd(next_half), pick_raw(), pick_raw());
      next_half = ~next_half;
      repeat (pdbp_pkg::MAX_BLOCK + 6) offer(pdbp_pkg::CMD_FRAME, pick_raw(), pick_raw());

      // Last part, no idling: overruns, a repeated half and a resync.
      calm <= 1'b1;
      write_config(5'd8, 15'd32767, 11'd4);
      repeat (3) offer(pdbp_pkg::CMD_FIRST, pick_raw(), pick_raw());
      offer(pdbp_pkg::CMD_SECOND, pick_raw(), pick_raw());
      repeat (8) offer(pdbp_pkg::CMD_FRAME, pick_raw(), pick_raw());
      offer(pdbp_pkg::CMD_SECOND, pick_raw(), pick_raw());
      offer(pdbp_pkg::CMD_SECOND, pick_raw(), pick_raw());
      offer(pdbp_pkg::CMD_FRAME, pick_raw(), pick_raw());
      settle();

      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
